FILE: rtl/core/twa_pkg.sv
package twa_pkg;

  localparam int unsigned WINDOW_W  = 24;
  localparam int unsigned ELAPSED_W = 20;
  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned AVG_W     = 18;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 24'd100000;

  localparam int unsigned MAX_COUNT_DEF   = 65536;
  localparam int unsigned SAMPLE_BITS_DEF = 10;
  localparam int unsigned FRAC_BITS_DEF   = 8;

  typedef struct packed {
    logic load;
    logic div_step;
    logic push;
  } twa_cmd_t;

  typedef struct packed {
    logic closed;
  } twa_sts_t;

endpackage

FILE: rtl/core/twa_in_if.sv
interface twa_in_if;
  logic                           valid;
  logic                           ready;
  logic [twa_pkg::ELAPSED_W-1:0]  elapsed_us;
  logic [twa_pkg::SAMPLE_W-1:0]   sample;

  modport source (output valid, output elapsed_us, output sample, input ready);
  modport sink   (input valid, input elapsed_us, input sample, output ready);
endinterface

FILE: rtl/core/twa_out_if.sv
interface twa_out_if;
  logic                       valid;
  logic                       ready;
  logic [twa_pkg::AVG_W-1:0]  average_q8;
  logic                       window_closed;

  modport source (output valid, output average_q8, output window_closed, input ready);
  modport sink   (input valid, input average_q8, input window_closed, output ready);
endinterface

FILE: rtl/core/twa_ctrl.sv
module twa_ctrl #(
  parameter int unsigned DVD_W = 35
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  twa_pkg::twa_sts_t sts_i,
  output twa_pkg::twa_cmd_t cmd_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = CNT_W'(DVD_W - 1);
          state_d    = sts_i.closed ? S_DIV : S_PUSH;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_PUSH;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_PUSH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/core/twa_datapath.sv
module twa_datapath #(
  parameter int unsigned MAX_COUNT   = twa_pkg::MAX_COUNT_DEF,
  parameter int unsigned SAMPLE_BITS = twa_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = twa_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [twa_pkg::WINDOW_W-1:0]  cfg_wdata_i,
  input  logic [twa_pkg::ELAPSED_W-1:0] elapsed_us_i,
  input  logic [twa_pkg::SAMPLE_W-1:0]  sample_i,
  input  twa_pkg::twa_cmd_t             cmd_i,
  output twa_pkg::twa_sts_t             sts_o,
  output logic [twa_pkg::AVG_W-1:0]     average_q8_o,
  output logic                          window_closed_o
);

  localparam int unsigned SMP_W   = (SAMPLE_BITS < twa_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                                       : twa_pkg::SAMPLE_W;
  localparam int unsigned COUNT_W = $clog2(MAX_COUNT + 1);
  localparam int unsigned SUM_W   = SMP_W + COUNT_W;
  localparam int unsigned DVD_W   = SUM_W + FRAC_BITS;
  localparam int unsigned WIN_W   = twa_pkg::WINDOW_W;
  localparam int unsigned AVG_W   = twa_pkg::AVG_W;

  logic [WIN_W-1:0]   window_q;
  logic [WIN_W-1:0]   time_q;
  logic [SUM_W-1:0]   sum_q;
  logic [COUNT_W-1:0] count_q;
  logic [AVG_W-1:0]   held_q;

  logic [DVD_W-1:0]   dvd_q;
  logic [COUNT_W-1:0] dvs_q;
  logic [COUNT_W-1:0] rem_q;
  logic [AVG_W-1:0]   quo_q;
  logic               zero_q;
  logic               closed_q;

  logic [AVG_W-1:0]   out_avg_q;
  logic               out_closed_q;

  logic [WIN_W:0]     time_sum;
  logic [COUNT_W:0]   rem_sh;
  logic               q_bit;
  logic [AVG_W-1:0]   held_d;

  assign time_sum     = {1'b0, time_q} + (WIN_W + 1)'(elapsed_us_i);
  assign sts_o.closed = !(time_sum < {1'b0, window_q});

  assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, dvs_q});

  assign held_d = closed_q ? (zero_q ? '0 : quo_q) : held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= twa_pkg::WINDOW_RESET;
      time_q   <= '0;
      sum_q    <= '0;
      count_q  <= '0;
      held_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        if (sts_o.closed) begin
          time_q  <= '0;
          sum_q   <= '0;
          count_q <= '0;
        end else begin
          time_q <= time_sum[WIN_W-1:0];
          if (count_q < COUNT_W'(MAX_COUNT)) begin
            sum_q   <= sum_q + SUM_W'(sample_i[SMP_W-1:0]);
            count_q <= count_q + 1'b1;
          end
        end
      end
      if (cmd_i.push) begin
        held_q <= held_d;
      end
    end
  end

  // restoring divide, one quotient bit per step; only the low result bits are kept
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      closed_q <= sts_o.closed;
      dvd_q    <= DVD_W'(sum_q) << FRAC_BITS;
      dvs_q    <= count_q;
      zero_q   <= (count_q == '0);
      rem_q    <= '0;
      quo_q    <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= dvd_q << 1;
      quo_q <= {quo_q[AVG_W-2:0], q_bit};
      if (q_bit) begin
        rem_q <= COUNT_W'(rem_sh - {1'b0, dvs_q});
      end else begin
        rem_q <= rem_sh[COUNT_W-1:0];
      end
    end
    if (cmd_i.push) begin
      out_avg_q    <= held_d;
      out_closed_q <= closed_q;
    end
  end

  assign average_q8_o    = out_avg_q;
  assign window_closed_o = out_closed_q;

endmodule

FILE: rtl/core/time_window_average_core.sv
// Time-window boxcar average of a sensor sample.
// in_i carries one request per sample: elapsed_us since the previous sample and the
// raw sample. out_o returns one result per request: the held average (8 fraction
// bits by default) and window_closed, set when that request closed a window.
// cfg_we_i/cfg_wdata_i write the window length; write only while idle.
// A request that keeps the window open goes from acceptance to the push state and
// then into the output register once that register is free. A closing request
// first runs a restoring divider, one quotient bit per cycle, over the smaller
// of SAMPLE_BITS and SAMPLE_W plus clog2(MAX_COUNT+1) + FRAC_BITS bits (35 by
// default), and is then pushed the same way. One request is in work at a time; the
// next is accepted once the previous result has moved into the output register.
// The output register holds a result while the receiver stalls; one more request
// may be accepted and worked on meanwhile, and then waits for the register.
// Reset clears the accumulated time, sum, count and held average, and sets the
// window length to 100000 us.
module time_window_average_core #(
  parameter int unsigned MAX_COUNT   = twa_pkg::MAX_COUNT_DEF,
  parameter int unsigned SAMPLE_BITS = twa_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = twa_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [twa_pkg::WINDOW_W-1:0] cfg_wdata_i,
  twa_in_if.sink                       in_i,
  twa_out_if.source                    out_o
);

  localparam int unsigned SMP_W = (SAMPLE_BITS < twa_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                                     : twa_pkg::SAMPLE_W;
  localparam int unsigned DVD_W = SMP_W + $clog2(MAX_COUNT + 1) + FRAC_BITS;

  twa_pkg::twa_cmd_t cmd;
  twa_pkg::twa_sts_t sts;

  twa_ctrl #(
    .DVD_W (DVD_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  twa_datapath #(
    .MAX_COUNT   (MAX_COUNT),
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .elapsed_us_i    (in_i.elapsed_us),
    .sample_i        (in_i.sample),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .average_q8_o    (out_o.average_q8),
    .window_closed_o (out_o.window_closed)
  );

`ifndef ASSERT_OFF
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> !cmd.div_step && !cmd.push)
    else $error("load issued together with another command");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> !out_o.valid || out_o.ready)
    else $error("result pushed over a waiting result");

  a_div_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load && sts.closed |=> cmd.div_step && !in_i.ready)
    else $error("closing request did not start the divider");

  a_open_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load && !sts.closed |=> !cmd.div_step)
    else $error("divider ran for a request that kept the window open");
`endif

endmodule

FILE: dv/time_window_average_core_tb.sv
module time_window_average_core_tb;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned MAX_CNT     = twa_pkg::MAX_COUNT_DEF;

  typedef logic [twa_pkg::AVG_W-1:0] avg_t;

  typedef struct packed {
    avg_t avg;
    logic closed;
  } avg_res_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e                     kind;
    logic [twa_pkg::WINDOW_W-1:0]  win;
    logic [twa_pkg::ELAPSED_W-1:0] el;
    logic [twa_pkg::SAMPLE_W-1:0]  smp;
    logic                          chk;
    avg_t                          avg;
    logic                          closed;
  } dir_row_t;

  localparam int unsigned N_ROWS = 23;

  // chk set: expectation typed in; otherwise taken from the predictor
  localparam dir_row_t DIR_ROWS [N_ROWS] = '{
    '{ROW_REQ, 24'd0,    20'd0,       10'h000, 1'b1, 18'd0,      1'b0},
    '{ROW_REQ, 24'd0,    20'hFFFFF,   10'h3FF, 1'b1, 18'd0,      1'b1},
    '{ROW_REQ, 24'd0,    20'd0,       10'h3FF, 1'b1, 18'd0,      1'b0},
    '{ROW_REQ, 24'd0,    20'd99999,   10'h000, 1'b1, 18'd0,      1'b0},
    '{ROW_REQ, 24'd0,    20'd1,       10'h005, 1'b1, 18'd130944, 1'b1},
    '{ROW_REQ, 24'd0,    20'd100000,  10'h007, 1'b1, 18'd0,      1'b1},
    '{ROW_REQ, 24'd0,    20'd50000,   10'h3FF, 1'b1, 18'd0,      1'b0},
    '{ROW_REQ, 24'd0,    20'd50000,   10'h000, 1'b1, 18'd261888, 1'b1},
    '{ROW_REQ, 24'd0,    20'd10,      10'h001, 1'b0, 18'd0,      1'b0},
    '{ROW_REQ, 24'd0,    20'd10,      10'h001, 1'b0, 18'd0,      1'b0},
    '{ROW_REQ, 24'd0,    20'd10,      10'h002, 1'b0, 18'd0,      1'b0},
    '{ROW_REQ, 24'd0,    20'd99970,   10'h000, 1'b1, 18'd341,    1'b1},
    '{ROW_REQ, 24'd0,    20'h55555,   10'h2AA, 1'b0, 18'd0,      1'b0},
    '{ROW_REQ, 24'd0,    20'h00001,   10'h155, 1'b0, 18'd0,      1'b0},
    '{ROW_REQ, 24'd0,    20'hAAAAA,   10'h000, 1'b0, 18'd0,      1'b0},
    '{ROW_CFG, 24'd0,    20'd0,       10'h000, 1'b0, 18'd0,      1'b0},
    '{ROW_REQ, 24'd0,    20'd0,       10'h3FF, 1'b1, 18'd0,      1'b1},
    '{ROW_REQ, 24'd0,    20'hFFFFF,   10'h3FF, 1'b1, 18'd0,      1'b1},
    '{ROW_CFG, 24'd1000, 20'd0,       10'h000, 1'b0, 18'd0,      1'b0},
    '{ROW_REQ, 24'd0,    20'd600,     10'd100, 1'b0, 18'd0,      1'b0},
    '{ROW_REQ, 24'd0,    20'd300,     10'd200, 1'b0, 18'd0,      1'b0},
    '{ROW_CFG, 24'd500,  20'd0,       10'h000, 1'b0, 18'd0,      1'b0},
    '{ROW_REQ, 24'd0,    20'd0,       10'd50,  1'b1, 18'd38400,  1'b1}
  };

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [twa_pkg::WINDOW_W-1:0] cfg_wdata_i;

  twa_in_if  in_if ();
  twa_out_if out_if ();

  time_window_average_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // predictor state
  logic [twa_pkg::WINDOW_W-1:0] win_len  = twa_pkg::WINDOW_RESET;
  logic [24:0]                  acc_us   = '0;
  logic [26:0]                  smp_sum  = '0;
  logic [16:0]                  smp_cnt  = '0;
  avg_t                         held_avg = '0;

  avg_res_t    pending_avg_q [$];
  bit          calm_q    = 1'b0;
  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= 20) $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  function automatic void boxcar_step(input logic [twa_pkg::ELAPSED_W-1:0] el,
                                      input logic [twa_pkg::SAMPLE_W-1:0] smp,
                                      output avg_res_t res);
    logic [24:0] t;
    logic [34:0] num;
    t = acc_us + 25'(el);
    res.closed = 1'b0;
    if (t < 25'(win_len)) begin
      if (smp_cnt < 17'(MAX_CNT)) begin
        smp_sum = smp_sum + 27'(smp);
        smp_cnt = smp_cnt + 17'd1;
      end
      acc_us = t;
    end else begin
      // closing sample discarded; empty window gives 0
      if (smp_cnt == '0) begin
        held_avg = '0;
      end else begin
        num = {smp_sum, 8'b0};
        held_avg = avg_t'(num / 35'(smp_cnt));
      end
      acc_us = '0;
      smp_sum = '0;
      smp_cnt = '0;
      res.closed = 1'b1;
    end
    res.avg = held_avg;
  endfunction

  task automatic send_req(input logic [twa_pkg::ELAPSED_W-1:0] el,
                          input logic [twa_pkg::SAMPLE_W-1:0] smp,
                          input logic use_typed, input avg_res_t typed);
    int unsigned gap;
    avg_res_t    res;
    gap = calm_q ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.elapsed_us <= el;
    in_if.sample     <= smp;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    boxcar_step(el, smp, res);
    pending_avg_q.push_back(use_typed ? typed : res);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_avg_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [twa_pkg::WINDOW_W-1:0] win);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= win;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    win_len = win;
  endtask

  task automatic run_window_phase(input logic [twa_pkg::WINDOW_W-1:0] win,
                                  input int unsigned n);
    int unsigned                   lim;
    logic [twa_pkg::ELAPSED_W-1:0] el;
    drain_results();
    write_window(win);
    lim = win / 6;
    if (lim > 32'hFFFFF) lim = 32'hFFFFF;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 40 == 0) calm_q = ($urandom_range(0, 3) == 0);
      if (i == n / 2) drain_results();
      case ($urandom_range(0, 9))
        0: el = twa_pkg::ELAPSED_W'($urandom);
        1: el = '0;
        2: el = '1;
        default: el = twa_pkg::ELAPSED_W'($urandom_range(0, lim));
      endcase
      send_req(el, twa_pkg::SAMPLE_W'($urandom), 1'b0, '0);
    end
    calm_q = 1'b0;
  endtask

  // result side
  initial begin
    int unsigned stall;
    avg_res_t    want;
    out_if.ready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      stall = calm_q ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      if (pending_avg_q.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = pending_avg_q.pop_front();
        if (out_if.average_q8 !== want.avg)
          report_mismatch($sformatf("average_q8 %0d, want %0d", out_if.average_q8, want.avg));
        if (out_if.window_closed !== want.closed)
          report_mismatch($sformatf("window_closed %0b, want %0b",
                                    out_if.window_closed, want.closed));
      end
    end
  end

  // request side
  initial begin
    dir_row_t row;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_wdata_i      <= '0;
    in_if.valid      <= 1'b0;
    in_if.elapsed_us <= '0;
    in_if.sample     <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned i = 0; i < N_ROWS; i++) begin
      row = DIR_ROWS[i];
      if (row.kind == ROW_CFG) begin
        drain_results();
        write_window(row.win);
      end else begin
        send_req(row.el, row.smp, row.chk, '{avg: row.avg, closed: row.closed});
      end
    end

    run_window_phase('1, 90);
    run_window_phase(twa_pkg::WINDOW_W'(1), 60);
    run_window_phase('0, 30);
    run_window_phase(twa_pkg::WINDOW_W'(3000), 120);
    run_window_phase(twa_pkg::WINDOW_RESET, 120);
    run_window_phase(twa_pkg::WINDOW_W'($urandom_range(2, 24'hFFFFFE)), 130);

    drain_results();
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
